// ===== rtl/cfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsm_pkg: shared types and helpers of the case-folding substring matcher
// Holds the beat structs, command and status codes, and the character compare.
// ----------------------------------------------------------------------------
package cfsm_pkg;

  // Width of a character on the ports.
  localparam int CharW = 16;
  // Width of a character position counter.
  localparam int PosW = 32;

  // Distance between an ASCII upper-case letter and its lower-case form.
  localparam logic [CharW-1:0] CaseOffs = 16'h0020;
  localparam logic [CharW-1:0] UpperLo  = 16'h0041;
  localparam logic [CharW-1:0] UpperHi  = 16'h005A;

  // Command codes.
  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdText   = 2'd2
  } cmd_e;

  // Status codes.
  typedef enum logic [1:0] {
    StNone  = 2'd0,
    StMatch = 2'd1,
    StFull  = 2'd2
  } status_e;

  // One input beat.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [CharW-1:0] char_value;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] match_end;
  } out_beat_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic clear_pat;
    logic clear_txt;
    logic shift_pat;
    logic shift_txt;
  } cell_ctl_t;

  // Character compare; with folding an upper-case letter on either side
  // also equals the lower-case letter on the other.
  function automatic logic char_eq(logic [CharW-1:0] t, logic [CharW-1:0] p,
                                   logic fold);
    logic t_up;
    logic p_up;
    logic folded;
    t_up = (t >= UpperLo) && (t <= UpperHi);
    p_up = (p >= UpperLo) && (p <= UpperHi);
    if (t_up) begin
      folded = ((t + CaseOffs) == p);
    end else if (p_up) begin
      folded = (t == (p + CaseOffs));
    end else begin
      folded = 1'b0;
    end
    return (t == p) || (fold && folded);
  endfunction

endpackage

// ===== rtl/cfsm_cell.sv =====
// ----------------------------------------------------------------------------
// cfsm_cell: one cell of the matcher chain
// Holds one pattern character and one text character with their valid bits,
// takes both from its left neighbor on a shift, and reports whether its
// pattern character agrees with the text character arriving this cycle.
// ----------------------------------------------------------------------------
module cfsm_cell #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfsm_pkg::cell_ctl_t ctl_i,
  input  logic                fold_i,
  input  logic [W-1:0]        pat_left_i,
  input  logic                pv_left_i,
  input  logic [W-1:0]        txt_left_i,
  input  logic                tv_left_i,
  output logic [W-1:0]        pat_o,
  output logic                pv_o,
  output logic [W-1:0]        txt_o,
  output logic                tv_o,
  output logic                ok_o
);
  import cfsm_pkg::*;

  logic [W-1:0] pat_q, pat_d;
  logic [W-1:0] txt_q, txt_d;
  logic         pv_q, pv_d;
  logic         tv_q, tv_d;
  logic [CharW-1:0] t_ext;
  logic [CharW-1:0] p_ext;

  // Next state: pattern and text move one cell to the right on a shift.
  always_comb begin
    pat_d = ctl_i.shift_pat ? pat_left_i : pat_q;
    txt_d = ctl_i.shift_txt ? txt_left_i : txt_q;
    if (ctl_i.clear_pat) begin
      pv_d = 1'b0;
    end else if (ctl_i.shift_pat) begin
      pv_d = pv_left_i;
    end else begin
      pv_d = pv_q;
    end
    if (ctl_i.clear_txt) begin
      tv_d = 1'b0;
    end else if (ctl_i.shift_txt) begin
      tv_d = tv_left_i;
    end else begin
      tv_d = tv_q;
    end
  end

  // Valid bits are control state and reset; the characters need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      tv_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
      tv_q <= tv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    txt_q <= txt_d;
  end

  // Compare against the text character that moves into this cell.
  always_comb begin
    t_ext = CharW'(txt_left_i);
    p_ext = CharW'(pat_q);
    ok_o  = !pv_q || (tv_left_i && char_eq(t_ext, p_ext, fold_i));
  end

  assign pat_o = pat_q;
  assign pv_o  = pv_q;
  assign txt_o = txt_q;
  assign tv_o  = tv_q;

endmodule

// ===== rtl/case_fold_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// case_fold_substring_matcher: streaming substring search with case folding
// Loads a pattern and reports each text position where it ends, without
// overlap between matches.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle and returns its result beat in the
// next cycle from an output register. A new beat is accepted in any cycle in
// which that register is empty or its result is taken in the same cycle, so a
// stalled result holds the input back. The figure is set by the row
// of PAT_MAX cells: on a text beat every cell compares its stored pattern
// character with the text character moving into it, and the agreement bits
// of all cells are combined in the same cycle. Pattern characters shift into
// the row from the left on each append that finds room, so the newest
// appended character lines up with the newest text character. After reset
// the pattern is empty and case folding is on; no clearing pass is needed.
module case_fold_substring_matcher #(
  parameter int PAT_MAX   = 64,
  parameter int CHAR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cfsm_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfsm_pkg::out_beat_t  out_data_o
);
  import cfsm_pkg::*;

  // Characters are stored at the masked width.
  localparam int StoreW = (CHAR_BITS < CharW) ? CHAR_BITS : CharW;

  logic                  fold_q;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_q, out_d;
  logic                  in_fire;
  logic                  is_clr, is_app, is_txt;
  logic                  full;
  logic                  match;
  logic [StoreW-1:0]     ch;
  cell_ctl_t             ctl;
  logic [StoreW-1:0]     pat_vec [PAT_MAX];
  logic [StoreW-1:0]     txt_vec [PAT_MAX];
  logic [PAT_MAX-1:0]    pv_vec;
  logic [PAT_MAX-1:0]    tv_vec;
  logic [PAT_MAX-1:0]    ok_vec;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b1;
    end else if (cfg_we_i) begin
      fold_q <= cfg_data_i;
    end
  end

  // Command decode.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ch         = in_data_i.char_value[StoreW-1:0];

  always_comb begin
    is_clr = 1'b0;
    is_app = 1'b0;
    is_txt = 1'b0;
    unique case (in_data_i.cmd)
      CmdClear:  is_clr = in_fire;
      CmdAppend: is_app = in_fire;
      CmdText:   is_txt = in_fire;
      default:   ;
    endcase
  end

  assign full  = pv_vec[PAT_MAX-1];
  assign match = is_txt && pv_vec[0] && (&ok_vec);

  always_comb begin
    ctl.clear_pat = is_clr;
    ctl.clear_txt = is_clr || match;
    ctl.shift_pat = is_app && !full;
    ctl.shift_txt = is_txt;
  end

  // The row of cells; cell 0 is fed from the input beat.
  for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
    logic [StoreW-1:0] pat_left;
    logic [StoreW-1:0] txt_left;
    logic              pv_left;
    logic              tv_left;
    if (k == 0) begin : g_head
      assign pat_left = ch;
      assign txt_left = ch;
      assign pv_left  = 1'b1;
      assign tv_left  = 1'b1;
    end else begin : g_body
      assign pat_left = pat_vec[k-1];
      assign txt_left = txt_vec[k-1];
      assign pv_left  = pv_vec[k-1];
      assign tv_left  = tv_vec[k-1];
    end
    cfsm_cell #(
      .W (StoreW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .fold_i     (fold_q),
      .pat_left_i (pat_left),
      .pv_left_i  (pv_left),
      .txt_left_i (txt_left),
      .tv_left_i  (tv_left),
      .pat_o      (pat_vec[k]),
      .pv_o       (pv_vec[k]),
      .txt_o      (txt_vec[k]),
      .tv_o       (tv_vec[k]),
      .ok_o       (ok_vec[k])
    );
  end

  // Text position and the result beat.
  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (is_clr) begin
      pos_d = '0;
    end else if (is_txt) begin
      pos_d = pos_q + PosW'(1);
    end
    if (in_fire) begin
      out_valid_d     = 1'b1;
      out_d.status    = StNone;
      out_d.match_end = '0;
      if (match) begin
        out_d.status    = StMatch;
        out_d.match_end = pos_q + PosW'(1);
      end else if (is_app && full) begin
        out_d.status = StFull;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A match empties the text history so the next match cannot overlap.
  a_match_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> (tv_vec == '0))
    else $error("text history not cleared after a match");

  // Pattern valid bits always fill from the head of the row.
  a_pat_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((pv_vec >> 1) & ~pv_vec) == '0))
    else $error("pattern valid bits have a gap");

  // A clear beat empties the pattern and restarts the position.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_clr |=> (pv_vec == '0) && (pos_q == '0))
    else $error("clear beat did not reset pattern and position");

  // A refused append is reported only when the row is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.cmd == CmdAppend) && !full) |=>
      (out_q.status == StNone))
    else $error("append refused while pattern had room");

endmodule
